// ===== rtl/ccct_pkg.sv =====
// ----------------------------------------------------------------------------
// ccct_pkg
// Types and codes shared by the call-site counter table modules.
// ----------------------------------------------------------------------------
package ccct_pkg;

	localparam int KEY_W    = 64;
	localparam int LEN_W    = 32;
	localparam int SLOT_W   = 12;
	localparam int CNT_W    = 64;
	localparam int STATUS_W = 3;

	// home slot comes from the key without its two low bits
	localparam int HOME_SHIFT = 2;

	// remainder unit: 16-bit chunks, one reciprocal multiply per chunk
	localparam int CHUNK_W     = 16;
	localparam int CHUNKS      = 4;
	localparam int CHUNK_CNT_W = 3;
	localparam int OPND_W      = CHUNK_W * CHUNKS;

	localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERT     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_VALID = 3'd3;
	localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ZERO_KEY   = 3'd5;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [1:0] {
		OP_RECORD,
		OP_READ,
		OP_ZERO
	} op_t;

	typedef struct packed {
		logic              mode;
		logic [KEY_W-1:0]  call_site;
		logic [LEN_W-1:0]  length;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_index;
		logic [KEY_W-1:0]    key_out;
		logic [CNT_W-1:0]    event_count;
		logic [CNT_W-1:0]    byte_total;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
	} qitem_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] bytes;
	} entry_t;

endpackage

// ===== rtl/call_site_copy_counter_table.sv =====
// ----------------------------------------------------------------------------
// call_site_copy_counter_table
// Per-key event and byte counters in an open-addressed table.
//
//  channel   | handshake           | payload
//  ----------+---------------------+--------------------------------------
//  request   | start, busy         | req  (mode, call_site, length, slot)
//  result    | done, one cycle     | rsp  (status, slot_index, key_out,
//            |                     |       event_count, byte_total)
//
// After reset the slot memory is cleared, one slot per cycle; busy stays high
// until that pass ends.
// A record transaction reads its home slot and then one further slot per
// occupied slot that does not hold its key (one memory read per probe).
// Reads look at a single slot; zero keys read no slot. If SLOTS is not a power
// of two the front works out the modulo in 16-bit chunks of the operand (four
// for a record, one for a read), each chunk through the F_MUL and F_FIX states.
// The two-entry queue lets the front take the next transaction while the
// prober works; done is never held back by the receiver.
// ----------------------------------------------------------------------------
module call_site_copy_counter_table import ccct_pkg::*; #(
	parameter int SLOTS = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = $clog2(SLOTS);

	logic          accept;
	logic          fr_busy;
	logic          clearing;
	logic          push;
	qitem_t        push_item;
	logic [IW-1:0] push_idx;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	qitem_t        head;
	logic [IW-1:0] head_idx;

	assign busy   = fr_busy | clearing;
	assign accept = start & ~busy;

	ccct_front #(.SLOTS(SLOTS), .IW(IW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.q_full   (q_full),
		.fr_busy  (fr_busy),
		.push     (push),
		.item     (push_item),
		.item_idx (push_idx)
	);

	ccct_queue #(.IW(IW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.push_idx  (push_idx),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head),
		.head_idx  (head_idx)
	);

	ccct_back #(.SLOTS(SLOTS), .IW(IW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.head_idx (head_idx),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/ccct_front.sv =====
// ----------------------------------------------------------------------------
// ccct_front
// Takes a transaction, classifies it and works out the table index.
// ----------------------------------------------------------------------------
module ccct_front import ccct_pkg::*; #(
	parameter int SLOTS = 4096,
	parameter int IW    = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  req_t          req,
	input  logic          q_full,
	output logic          fr_busy,
	output logic          push,
	output qitem_t        item,
	output logic [IW-1:0] item_idx
);

	localparam int            PW       = 2 * CHUNK_W;
	localparam logic          IS_POW2  = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [PW-1:0] MOD_WIDE = PW'(SLOTS);
	localparam logic [PW-1:0] RECIP    = PW'((64'd1 << PW) / 64'(SLOTS));

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_FIX,
		F_PUSH
	} fstate_t;

	fstate_t                state_q;
	qitem_t                 item_q;
	logic [IW-1:0]          idx_q;
	logic [CHUNK_W-1:0]     rem_q;
	logic [OPND_W-1:0]      opnd_q;
	logic [CHUNK_CNT_W-1:0] chunks_q;
	logic [CHUNK_W-1:0]     quot_q;

	logic [IW-1:0]        home_direct;
	logic [IW+SLOT_W-1:0] slot_ext;
	logic [IW-1:0]        slot_direct;
	logic [PW-1:0]        val;
	logic [2*PW-1:0]      prod;
	logic [PW-1:0]        qm;
	logic [PW-1:0]        r_raw;
	logic [CHUNK_W-1:0]   rem_next;
	logic                 zero_key;

	assign home_direct = req.call_site[IW+HOME_SHIFT-1:HOME_SHIFT];
	assign slot_ext    = {{IW{1'b0}}, req.slot};
	assign slot_direct = slot_ext[IW-1:0];
	assign zero_key    = (req.call_site == '0);

	// running remainder and next chunk; quotient estimate is low by at most one
	assign val      = {rem_q, opnd_q[OPND_W-1 -: CHUNK_W]};
	assign prod     = (2*PW)'(val) * (2*PW)'(RECIP);
	assign qm       = PW'(quot_q) * MOD_WIDE;
	assign r_raw    = val - qm;
	assign rem_next = (r_raw >= MOD_WIDE) ? CHUNK_W'(r_raw - MOD_WIDE) : r_raw[CHUNK_W-1:0];

	assign fr_busy  = (state_q != F_IDLE);
	assign push     = (state_q == F_PUSH) && !q_full;
	assign item     = item_q;
	assign item_idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						item_q.key <= req.call_site;
						item_q.len <= req.length;
						rem_q      <= '0;
						if (req.mode == MODE_READ) begin
							item_q.op <= OP_READ;
							opnd_q    <= {CHUNK_W'(req.slot), {(OPND_W-CHUNK_W){1'b0}}};
							chunks_q  <= CHUNK_CNT_W'(1);
							idx_q     <= slot_direct;
							state_q   <= IS_POW2 ? F_PUSH : F_MUL;
						end else if (zero_key) begin
							item_q.op <= OP_ZERO;
							idx_q     <= '0;
							state_q   <= F_PUSH;
						end else begin
							item_q.op <= OP_RECORD;
							opnd_q    <= {{HOME_SHIFT{1'b0}}, req.call_site[KEY_W-1:HOME_SHIFT]};
							chunks_q  <= CHUNK_CNT_W'(CHUNKS);
							idx_q     <= home_direct;
							state_q   <= IS_POW2 ? F_PUSH : F_MUL;
						end
					end
				end
				F_MUL: begin
					quot_q  <= prod[PW +: CHUNK_W];
					state_q <= F_FIX;
				end
				F_FIX: begin
					rem_q    <= rem_next;
					opnd_q   <= opnd_q << CHUNK_W;
					chunks_q <= chunks_q - 1'b1;
					if (chunks_q == CHUNK_CNT_W'(1)) begin
						idx_q   <= IW'(rem_next);
						state_q <= F_PUSH;
					end else begin
						state_q <= F_MUL;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/ccct_queue.sv =====
// ----------------------------------------------------------------------------
// ccct_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ccct_queue import ccct_pkg::*; #(
	parameter int IW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qitem_t        push_item,
	input  logic [IW-1:0] push_idx,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output qitem_t        head,
	output logic [IW-1:0] head_idx
);

	localparam int         W     = $bits(qitem_t) + IW;
	localparam logic [1:0] DEPTH = 2'd2;

	logic [W-1:0] ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full             = (cnt_q == DEPTH);
	assign empty            = (cnt_q == 2'd0);
	assign {head, head_idx} = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= {push_item, push_idx};
		end
	end

endmodule

// ===== rtl/ccct_back.sv =====
// ----------------------------------------------------------------------------
// ccct_back
// Slot memory, clearing pass and the linear probe sequencer.
// ----------------------------------------------------------------------------
module ccct_back import ccct_pkg::*; #(
	parameter int SLOTS = 4096,
	parameter int IW    = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  qitem_t        head,
	input  logic [IW-1:0] head_idx,
	output logic          pop,
	output logic          clearing,
	output logic          done,
	output rsp_t          rsp
);

	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EVAL
	} bstate_t;

	entry_t mem [SLOTS];

	bstate_t       state_q;
	qitem_t        cur_q;
	logic [IW-1:0] addr_q;
	logic [IW-1:0] probes_q;
	logic [IW-1:0] clr_q;
	entry_t        rd_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic             we;
	logic [IW-1:0]    wa;
	entry_t           wd;
	entry_t           upd;
	logic             hit;
	logic             vacant;
	logic [IW-1:0]    next_addr;
	logic [IW+11:0]   addr_ext;
	logic [SLOT_W-1:0] slot12;

	assign pop       = (state_q == B_IDLE) && !q_empty;
	assign clearing  = (state_q == B_CLEAR);
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign hit       = (rd_q.key == cur_q.key);
	assign vacant    = (rd_q.key == '0);
	assign next_addr = (addr_q == LAST) ? '0 : addr_q + 1'b1;
	assign addr_ext  = {12'b0, addr_q};
	assign slot12    = addr_ext[SLOT_W-1:0];

	assign upd.key   = cur_q.key;
	assign upd.count = rd_q.count + 1'b1;
	assign upd.bytes = rd_q.bytes + CNT_W'(cur_q.len);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q;
		we      = 1'b0;
		wa      = addr_q;
		wd      = upd;
		case (state_q)
			B_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
			end
			B_IDLE: begin
				if (pop && head.op != OP_ZERO) begin
					rd_en   = 1'b1;
					rd_addr = head_idx;
				end
			end
			B_EVAL: begin
				if (cur_q.op == OP_RECORD) begin
					if (hit || vacant) begin
						we = 1'b1;
					end else if (probes_q != LAST) begin
						rd_en   = 1'b1;
						rd_addr = next_addr;
					end
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						cur_q    <= head;
						addr_q   <= head_idx;
						probes_q <= '0;
						if (head.op == OP_ZERO) begin
							done_q <= 1'b1;
							rsp_q  <= '{status: ST_ZERO_KEY, default: '0};
						end else begin
							state_q <= B_EVAL;
						end
					end
				end
				B_EVAL: begin
					if (cur_q.op == OP_READ) begin
						done_q            <= 1'b1;
						rsp_q.status      <= vacant ? ST_READ_EMPTY : ST_READ_VALID;
						rsp_q.slot_index  <= slot12;
						rsp_q.key_out     <= rd_q.key;
						rsp_q.event_count <= rd_q.count;
						rsp_q.byte_total  <= rd_q.bytes;
						state_q           <= B_IDLE;
					end else if (hit || vacant) begin
						done_q            <= 1'b1;
						rsp_q.status      <= vacant ? ST_INSERT : ST_HIT;
						rsp_q.slot_index  <= slot12;
						rsp_q.key_out     <= upd.key;
						rsp_q.event_count <= upd.count;
						rsp_q.byte_total  <= upd.bytes;
						state_q           <= B_IDLE;
					end else if (probes_q == LAST) begin
						done_q            <= 1'b1;
						rsp_q.status      <= ST_FULL;
						rsp_q.slot_index  <= '0;
						rsp_q.key_out     <= cur_q.key;
						rsp_q.event_count <= '0;
						rsp_q.byte_total  <= '0;
						state_q           <= B_IDLE;
					end else begin
						addr_q   <= next_addr;
						probes_q <= probes_q + 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
